// ===== rtl/swfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfr_pkg: shared types and constants for the stop-and-wait frame receiver
// Link byte codes, result and command encodings, command queue sizing.
// ----------------------------------------------------------------------------
package swfr_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_FLAG   = 8'h5E;
	localparam logic [7:0] ESC_ESC    = 8'h5D;
	localparam logic [7:0] CTRL_SEQ0  = 8'h00;
	localparam logic [7:0] CTRL_SEQ1  = 8'h40;
	localparam logic [7:0] RR_SEQ0    = 8'h05;
	localparam logic [7:0] RR_SEQ1    = 8'h85;
	localparam logic [7:0] REJ_SEQ0   = 8'h01;
	localparam logic [7:0] REJ_SEQ1   = 8'h81;
	localparam logic [7:0] ADDR_RESET = 8'h03;

	localparam int LEN_W = 9;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_VERDICT = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;

	// verdict codes
	localparam logic [2:0] VERD_ACCEPTED  = 3'd0;
	localparam logic [2:0] VERD_BAD_CHECK = 3'd1;
	localparam logic [2:0] VERD_DUPLICATE = 3'd2;
	localparam logic [2:0] VERD_BAD_ESC   = 3'd3;
	localparam logic [2:0] VERD_EMPTY     = 3'd4;
	localparam logic [2:0] VERD_OVERLONG  = 3'd5;

	// commands from the parser to the result sequencer
	localparam logic [1:0] CMD_PAYLOAD = 2'd0;
	localparam logic [1:0] CMD_ERROR   = 2'd1;
	localparam logic [1:0] CMD_FRAME   = 2'd2;

	// result steps of a finished frame
	localparam logic [2:0] STEP_VERDICT = 3'd0;
	localparam logic [2:0] STEP_OPEN    = 3'd1;
	localparam logic [2:0] STEP_ADDR    = 3'd2;
	localparam logic [2:0] STEP_CTRL    = 3'd3;
	localparam logic [2:0] STEP_CHECK   = 3'd4;
	localparam logic [2:0] STEP_CLOSE   = 3'd5;

	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0]       op;
		logic [7:0]       data;
		logic [2:0]       verdict;
		logic [LEN_W-1:0] length;
		logic             seq;
		logic [7:0]       ctrl;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       byte_value;
		logic [2:0]       verdict;
		logic [LEN_W-1:0] payload_length;
		logic             frame_sequence;
		logic             last;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/swfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfr_front: link byte parser
// Hunts for the header, unstuffs the body, holds one byte back for the
// check, and issues one command per item into the command queue.
// ----------------------------------------------------------------------------
module swfr_front #(
	parameter int MAX_PAYLOAD = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    link_address,
	input  wire logic          push,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          full,
	output logic               cmd_valid,
	output swfr_pkg::cmd_t     cmd
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_FLAG = 3'd1;
	localparam logic [2:0] PH_ADDR = 3'd2;
	localparam logic [2:0] PH_CTRL = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;

	logic [2:0]       phase_q, phase_d;
	logic             rseq_q, rseq_d;
	logic             eseq_q, eseq_d;
	logic             esc_q, esc_d;
	logic [7:0]       held_q, held_d;
	logic             held_v_q, held_v_d;
	logic [7:0]       chk_q, chk_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic       acc;
	logic       emit;
	logic       do_err;
	logic [2:0] err_code;
	logic       data_ok;
	logic [7:0] data;
	logic [7:0] hdr_ctrl;

	assign acc       = push && !full;
	assign cmd_valid = acc && emit;
	assign hdr_ctrl  = rseq_q ? swfr_pkg::CTRL_SEQ1 : swfr_pkg::CTRL_SEQ0;

	always_comb begin
		phase_d  = phase_q;
		rseq_d   = rseq_q;
		eseq_d   = eseq_q;
		esc_d    = esc_q;
		held_d   = held_q;
		held_v_d = held_v_q;
		chk_d    = chk_q;
		cnt_d    = cnt_q;
		emit     = 1'b0;
		do_err   = 1'b0;
		err_code = swfr_pkg::VERD_BAD_ESC;
		data_ok  = 1'b0;
		data     = rx_byte;
		cmd      = '0;
		cmd.seq  = rseq_q;
		case (phase_q)
			PH_FLAG: begin
				if (rx_byte == link_address) begin
					phase_d = PH_ADDR;
				end else if (rx_byte != swfr_pkg::FLAG_BYTE) begin
					phase_d = PH_HUNT;
				end
			end
			PH_ADDR: begin
				if (rx_byte == swfr_pkg::CTRL_SEQ0 || rx_byte == swfr_pkg::CTRL_SEQ1) begin
					rseq_d  = (rx_byte == swfr_pkg::CTRL_SEQ1);
					phase_d = PH_CTRL;
				end else begin
					phase_d = (rx_byte == swfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			end
			PH_CTRL: begin
				if (rx_byte == (link_address ^ hdr_ctrl)) begin
					phase_d  = PH_BODY;
					esc_d    = 1'b0;
					held_v_d = 1'b0;
					held_d   = '0;
					chk_d    = '0;
					cnt_d    = '0;
				end else begin
					phase_d = (rx_byte == swfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			end
			PH_BODY: begin
				if (esc_q) begin
					esc_d = 1'b0;
					if (rx_byte == swfr_pkg::ESC_FLAG) begin
						data    = swfr_pkg::FLAG_BYTE;
						data_ok = 1'b1;
					end else if (rx_byte == swfr_pkg::ESC_ESC) begin
						data    = swfr_pkg::ESC_BYTE;
						data_ok = 1'b1;
					end else begin
						do_err   = 1'b1;
						err_code = swfr_pkg::VERD_BAD_ESC;
					end
				end else if (rx_byte == swfr_pkg::FLAG_BYTE) begin
					if (!held_v_q) begin
						do_err   = 1'b1;
						err_code = swfr_pkg::VERD_EMPTY;
					end else begin
						// closing flag: held byte is the check
						emit       = 1'b1;
						phase_d    = PH_HUNT;
						cmd.op     = swfr_pkg::CMD_FRAME;
						cmd.length = swfr_pkg::LEN_W'(cnt_q);
						if (rseq_q != eseq_q) begin
							cmd.verdict = swfr_pkg::VERD_DUPLICATE;
							cmd.ctrl    = eseq_q ? swfr_pkg::RR_SEQ1 : swfr_pkg::RR_SEQ0;
						end else if (chk_q != held_q) begin
							cmd.verdict = swfr_pkg::VERD_BAD_CHECK;
							cmd.ctrl    = eseq_q ? swfr_pkg::REJ_SEQ1 : swfr_pkg::REJ_SEQ0;
						end else begin
							cmd.verdict = swfr_pkg::VERD_ACCEPTED;
							eseq_d      = !eseq_q;
							cmd.ctrl    = eseq_q ? swfr_pkg::RR_SEQ0 : swfr_pkg::RR_SEQ1;
						end
					end
				end else if (rx_byte == swfr_pkg::ESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					data_ok = 1'b1;
				end

				if (data_ok) begin
					if (held_v_q && cnt_q >= CNT_W'(MAX_PAYLOAD)) begin
						do_err   = 1'b1;
						err_code = swfr_pkg::VERD_OVERLONG;
					end else begin
						if (held_v_q) begin
							emit     = 1'b1;
							cmd.op   = swfr_pkg::CMD_PAYLOAD;
							cmd.data = held_q;
							chk_d    = chk_q ^ held_q;
							cnt_d    = cnt_q + 1'b1;
						end
						held_d   = data;
						held_v_d = 1'b1;
					end
				end

				if (do_err) begin
					emit        = 1'b1;
					cmd.op      = swfr_pkg::CMD_ERROR;
					cmd.verdict = err_code;
					cmd.length  = swfr_pkg::LEN_W'(cnt_q);
					phase_d     = PH_HUNT;
					esc_d       = 1'b0;
				end
			end
			default: begin
				phase_d = (rx_byte == swfr_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			rseq_q   <= 1'b0;
			eseq_q   <= 1'b0;
			esc_q    <= 1'b0;
			held_q   <= '0;
			held_v_q <= 1'b0;
			chk_q    <= '0;
			cnt_q    <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			rseq_q   <= rseq_d;
			eseq_q   <= eseq_d;
			esc_q    <= esc_d;
			held_q   <= held_d;
			held_v_q <= held_v_d;
			chk_q    <= chk_d;
			cnt_q    <= cnt_d;
		end
	end

`ifndef SYNTHESIS
	a_esc_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> phase_q == PH_BODY)
		else $error("escape pending outside frame body");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAYLOAD))
		else $error("payload count beyond limit");
`endif

endmodule
`default_nettype wire

// ===== rtl/swfr_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfr_cmd_fifo: command queue between parser and result sequencer
// Small register queue, one write and one read of the head per cycle.
// ----------------------------------------------------------------------------
module swfr_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire swfr_pkg::cmd_t wr_data,
	input  wire logic           rd_en,
	output swfr_pkg::cmd_t      rd_data,
	output logic                valid,
	output logic                full
);

	swfr_pkg::cmd_t                mem_q [swfr_pkg::CQ_DEPTH];
	logic [swfr_pkg::CQ_PTR_W-1:0] wp_q;
	logic [swfr_pkg::CQ_PTR_W-1:0] rp_q;
	logic [swfr_pkg::CQ_CNT_W-1:0] cnt_q;

	assign valid   = (cnt_q != '0);
	assign full    = (cnt_q == swfr_pkg::CQ_CNT_W'(swfr_pkg::CQ_DEPTH));
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |-> !full)
		else $error("command queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> valid)
		else $error("command queue underrun");
`endif

endmodule
`default_nettype wire

// ===== rtl/swfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swfr_back: result sequencer
// Expands each command into its results (one, or six for a finished frame)
// and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module swfr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     link_address,
	input  wire logic           head_valid,
	input  wire swfr_pkg::cmd_t head,
	output logic                rd_en,
	input  wire logic           pop,
	output logic                empty,
	output swfr_pkg::res_t      res
);

	logic [2:0]     step_q;
	logic           out_valid_q;
	swfr_pkg::res_t res_q;
	swfr_pkg::res_t res_d;
	logic           fin;
	logic           adv;
	logic           pop_ok;

	assign empty  = !out_valid_q;
	assign res    = res_q;
	assign pop_ok = pop && out_valid_q;
	assign adv    = head_valid && (!out_valid_q || pop);
	assign rd_en  = adv && fin;

	always_comb begin
		res_d = '0;
		fin   = 1'b1;
		case (head.op)
			swfr_pkg::CMD_PAYLOAD: begin
				res_d.kind           = swfr_pkg::KIND_PAYLOAD;
				res_d.byte_value     = head.data;
				res_d.frame_sequence = head.seq;
				res_d.last           = 1'b1;
			end
			swfr_pkg::CMD_ERROR: begin
				res_d.kind           = swfr_pkg::KIND_VERDICT;
				res_d.verdict        = head.verdict;
				res_d.payload_length = head.length;
				res_d.frame_sequence = head.seq;
				res_d.last           = 1'b1;
			end
			swfr_pkg::CMD_FRAME: begin
				fin        = 1'b0;
				res_d.kind = swfr_pkg::KIND_REPLY;
				case (step_q)
					swfr_pkg::STEP_VERDICT: begin
						res_d.kind           = swfr_pkg::KIND_VERDICT;
						res_d.verdict        = head.verdict;
						res_d.payload_length = head.length;
						res_d.frame_sequence = head.seq;
					end
					swfr_pkg::STEP_OPEN:  res_d.byte_value = swfr_pkg::FLAG_BYTE;
					swfr_pkg::STEP_ADDR:  res_d.byte_value = link_address;
					swfr_pkg::STEP_CTRL:  res_d.byte_value = head.ctrl;
					swfr_pkg::STEP_CHECK: res_d.byte_value = link_address ^ head.ctrl;
					swfr_pkg::STEP_CLOSE: begin
						res_d.byte_value = swfr_pkg::FLAG_BYTE;
						res_d.last       = 1'b1;
						fin              = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= swfr_pkg::STEP_VERDICT;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			step_q      <= fin ? swfr_pkg::STEP_VERDICT : step_q + 1'b1;
		end else if (pop_ok) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_step_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != swfr_pkg::STEP_VERDICT |-> head_valid && head.op == swfr_pkg::CMD_FRAME)
		else $error("reply step without a frame command at the head");
	a_retire_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> res_d.last)
		else $error("command retired without its last result");
`endif

endmodule
`default_nettype wire

// ===== rtl/stop_and_wait_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver: byte-stuffed stop-and-wait link receiver
// Header hunt, unstuffing, check, verdict and RR/REJ reply generation.
// ----------------------------------------------------------------------------
// The receiver takes one link byte per clock whenever full is low. Payload
// bytes come out one byte late (the last body byte is the check) and stay
// provisional until an accepted verdict. A closing flag after a check byte
// yields six results: the verdict followed by a five-byte RR or REJ reply;
// the result sequencer moves them out one per cycle while pop keeps the
// output register free, and the parser keeps taking bytes into a four-entry
// command queue meanwhile. Every other byte yields at most one result. Write
// link_address only while the block is idle.
module stop_and_wait_frame_receiver #(
	parameter int MAX_PAYLOAD = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       link_address_we,
	input  wire logic [7:0] link_address_wdata,
	input  wire logic       push,
	input  wire logic [7:0] rx_byte,
	output logic            full,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      kind,
	output logic [7:0]      byte_value,
	output logic [2:0]      verdict,
	output logic [8:0]      payload_length,
	output logic            frame_sequence,
	output logic            last
);

	logic [7:0]     link_address_q;
	logic           cmd_valid;
	swfr_pkg::cmd_t cmd;
	swfr_pkg::cmd_t head;
	logic           head_valid;
	logic           rd_en;
	swfr_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_address_q <= swfr_pkg::ADDR_RESET;
		end else if (link_address_we) begin
			link_address_q <= link_address_wdata;
		end
	end

	swfr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.link_address (link_address_q),
		.push         (push),
		.rx_byte      (rx_byte),
		.full         (full),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	swfr_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd),
		.rd_en   (rd_en),
		.rd_data (head),
		.valid   (head_valid),
		.full    (full)
	);

	swfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.link_address (link_address_q),
		.head_valid   (head_valid),
		.head         (head),
		.rd_en        (rd_en),
		.pop          (pop),
		.empty        (empty),
		.res          (res)
	);

	assign kind           = res.kind;
	assign byte_value     = res.byte_value;
	assign verdict        = res.verdict;
	assign payload_length = res.payload_length;
	assign frame_sequence = res.frame_sequence;
	assign last           = res.last;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for stop_and_wait_frame_receiver
// Feeds link bytes one item at a time and predicts the payload, verdict and
// reply items of every byte. Each popped item is compared with the oldest
// prediction. Covers headers, stuffing, error frames, max and overlong
// frames, output back-pressure, several link addresses and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
	import swfr_pkg::*;

	localparam int FRAME_MAX    = 256;
	localparam int RANDOM_ITEMS = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       link_address_we = 1'b0;
	logic [7:0] link_address_wdata = 8'h00;
	logic       push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic [2:0] verdict;
	logic [8:0] payload_length;
	logic       frame_sequence;
	logic       last;

	stop_and_wait_frame_receiver #(.MAX_PAYLOAD(FRAME_MAX)) i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.link_address_we    (link_address_we),
		.link_address_wdata (link_address_wdata),
		.push               (push),
		.rx_byte            (rx_byte),
		.full               (full),
		.empty              (empty),
		.pop                (pop),
		.kind               (kind),
		.byte_value         (byte_value),
		.verdict            (verdict),
		.payload_length     (payload_length),
		.frame_sequence     (frame_sequence),
		.last               (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// receiver model
	// ------------------------------------------------------------------
	typedef enum logic [2:0] {SEEK, SAW_FLAG, SAW_ADDR, SAW_CTRL, IN_BODY} parse_t;

	logic [7:0] addr_reg  = ADDR_RESET;
	parse_t     parse_ph  = SEEK;
	logic       rx_seq    = 1'b0;
	logic       want_seq  = 1'b0;
	logic       esc_open  = 1'b0;
	logic [7:0] hold_byte = 8'h00;
	logic       hold_ok   = 1'b0;
	logic [7:0] xor_acc   = 8'h00;
	int         body_cnt  = 0;

	res_t expected_q[$];
	res_t burst_q[$];

	int n_err = 0;
	int n_sent = 0;
	bit idling = 1'b1;
	int hold_req_cycles = 0;

	logic [7:0] tx_q[$];
	logic [7:0] body_q[$];

	function automatic res_t make_res(logic [1:0] k, logic [7:0] v, logic [2:0] vd,
			logic [8:0] len, logic s);
		res_t r;
		r.kind = k;
		r.byte_value = v;
		r.verdict = vd;
		r.payload_length = len;
		r.frame_sequence = s;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void close_error(logic [2:0] vd);
		burst_q.push_back(make_res(KIND_VERDICT, 8'h00, vd, 9'(body_cnt), rx_seq));
		parse_ph = SEEK;
		esc_open = 1'b0;
	endfunction

	function automatic void close_frame();
		logic [2:0] vd;
		logic [7:0] ctl;
		if (rx_seq != want_seq) begin
			vd = VERD_DUPLICATE;
			ctl = want_seq ? RR_SEQ1 : RR_SEQ0;
		end else if (xor_acc != hold_byte) begin
			vd = VERD_BAD_CHECK;
			ctl = want_seq ? REJ_SEQ1 : REJ_SEQ0;
		end else begin
			vd = VERD_ACCEPTED;
			want_seq = ~want_seq;
			ctl = want_seq ? RR_SEQ1 : RR_SEQ0;
		end
		burst_q.push_back(make_res(KIND_VERDICT, 8'h00, vd, 9'(body_cnt), rx_seq));
		burst_q.push_back(make_res(KIND_REPLY, FLAG_BYTE, '0, '0, 1'b0));
		burst_q.push_back(make_res(KIND_REPLY, addr_reg, '0, '0, 1'b0));
		burst_q.push_back(make_res(KIND_REPLY, ctl, '0, '0, 1'b0));
		burst_q.push_back(make_res(KIND_REPLY, addr_reg ^ ctl, '0, '0, 1'b0));
		burst_q.push_back(make_res(KIND_REPLY, FLAG_BYTE, '0, '0, 1'b0));
		parse_ph = SEEK;
	endfunction

	function automatic void body_step(logic [7:0] b);
		logic [7:0] d;
		d = b;
		if (esc_open) begin
			esc_open = 1'b0;
			if (b == ESC_FLAG)
				d = FLAG_BYTE;
			else if (b == ESC_ESC)
				d = ESC_BYTE;
			else begin
				close_error(VERD_BAD_ESC);
				return;
			end
		end else if (b == FLAG_BYTE) begin
			if (!hold_ok)
				close_error(VERD_EMPTY);
			else
				close_frame();
			return;
		end else if (b == ESC_BYTE) begin
			esc_open = 1'b1;
			return;
		end
		// the held byte goes out only once a later byte proves it is not the check
		if (hold_ok) begin
			if (body_cnt >= FRAME_MAX) begin
				close_error(VERD_OVERLONG);
				return;
			end
			burst_q.push_back(make_res(KIND_PAYLOAD, hold_byte, '0, '0, rx_seq));
			xor_acc ^= hold_byte;
			body_cnt++;
		end
		hold_byte = d;
		hold_ok = 1'b1;
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		res_t tail;
		burst_q.delete();
		case (parse_ph)
			SAW_FLAG: begin
				if (b == addr_reg)
					parse_ph = SAW_ADDR;
				else if (b != FLAG_BYTE)
					parse_ph = SEEK;
			end
			SAW_ADDR: begin
				if (b == CTRL_SEQ0 || b == CTRL_SEQ1) begin
					rx_seq = (b == CTRL_SEQ1);
					parse_ph = SAW_CTRL;
				end else begin
					parse_ph = (b == FLAG_BYTE) ? SAW_FLAG : SEEK;
				end
			end
			SAW_CTRL: begin
				if (b == (addr_reg ^ (rx_seq ? CTRL_SEQ1 : CTRL_SEQ0))) begin
					parse_ph = IN_BODY;
					esc_open = 1'b0;
					hold_ok = 1'b0;
					hold_byte = 8'h00;
					xor_acc = 8'h00;
					body_cnt = 0;
				end else begin
					parse_ph = (b == FLAG_BYTE) ? SAW_FLAG : SEEK;
				end
			end
			IN_BODY: begin
				body_step(b);
			end
			default: begin
				parse_ph = (b == FLAG_BYTE) ? SAW_FLAG : SEEK;
			end
		endcase
		if (burst_q.size() > 0) begin
			tail = burst_q.pop_back();
			tail.last = 1'b1;
			burst_q.push_back(tail);
		end
		foreach (burst_q[i])
			expected_q.push_back(burst_q[i]);
	endfunction

	// ------------------------------------------------------------------
	// frame building
	// ------------------------------------------------------------------
	function automatic logic [7:0] rnd_byte();
		logic [7:0] pick[4];
		pick = '{FLAG_BYTE, ESC_BYTE, 8'h00, 8'hFF};
		if ($urandom_range(0, 7) == 0)
			return pick[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_stuffed(logic [7:0] b);
		if (b == FLAG_BYTE) begin
			tx_q.push_back(ESC_BYTE);
			tx_q.push_back(ESC_FLAG);
		end else if (b == ESC_BYTE) begin
			tx_q.push_back(ESC_BYTE);
			tx_q.push_back(ESC_ESC);
		end else begin
			tx_q.push_back(b);
		end
	endfunction

	function automatic void put_header(logic s);
		logic [7:0] ctl;
		ctl = s ? CTRL_SEQ1 : CTRL_SEQ0;
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(addr_reg);
		tx_q.push_back(ctl);
		tx_q.push_back(addr_reg ^ ctl);
	endfunction

	function automatic void fill_body(int n);
		repeat (n) body_q.push_back(rnd_byte());
	endfunction

	// header, stuffed body_q, stuffed check byte, closing flag
	function automatic void put_frame(logic s, bit bad_check);
		logic [7:0] x;
		x = 8'h00;
		put_header(s);
		foreach (body_q[i]) begin
			put_stuffed(body_q[i]);
			x ^= body_q[i];
		end
		if (bad_check)
			x ^= 8'($urandom_range(1, 255));
		put_stuffed(x);
		tx_q.push_back(FLAG_BYTE);
		body_q.delete();
	endfunction

	// ------------------------------------------------------------------
	// link side driver
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		n_sent++;
		predict_byte(b);
	endtask

	task automatic send_tx();
		foreach (tx_q[i])
			send_byte(tx_q[i]);
		tx_q.delete();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		// a quiet margin after the last expected item has been popped
		repeat (12) @(negedge clk);
	endtask

	task automatic load_link_address(input logic [7:0] a);
		wait_idle();
		link_address_we <= 1'b1;
		link_address_wdata <= a;
		@(negedge clk);
		link_address_we <= 1'b0;
		addr_reg = a;
	endtask

	// ------------------------------------------------------------------
	// result side: pop driver and checker
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		int stall_left;
		logic nxt;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req_cycles > 0) begin
				hold_left = hold_req_cycles;
				hold_req_cycles = 0;
			end
			if (hold_left > 0) begin
				nxt = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				nxt = 1'b0;
				stall_left--;
			end else if (idling && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				nxt = 1'b0;
			end else begin
				nxt = 1'b1;
			end
			pop <= nxt;
		end
	end

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		n_err++;
	endtask

	always @(posedge clk) begin : check_items
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got = '{kind, byte_value, verdict, payload_length, frame_sequence, last};
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected item %p", got));
			end else begin
				want = expected_q.pop_front();
				if (got != want)
					report($sformatf("item mismatch: got %p expected %p", got, want));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_good_frames();
		// every stuffed code plus field extremes, accepted as sequence 0
		body_q = {8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE, ESC_FLAG, ESC_ESC};
		put_frame(1'b0, 1'b0);
		// repeat of sequence 0 with a bad check is still a duplicate
		fill_body(1);
		put_frame(1'b0, 1'b1);
		fill_body(1);
		put_frame(1'b1, 1'b1);
		// check byte only: zero-length payload, accepted
		put_frame(1'b1, 1'b0);
		send_tx();
	endtask

	task automatic test_error_frames();
		put_header(want_seq);
		tx_q.push_back(FLAG_BYTE);
		// escape followed by a flag
		put_header(want_seq);
		tx_q.push_back(8'h11);
		tx_q.push_back(ESC_BYTE);
		tx_q.push_back(FLAG_BYTE);
		// header mismatches at each position
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(addr_reg ^ 8'h01);
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(addr_reg);
		tx_q.push_back(8'h20);
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(addr_reg);
		tx_q.push_back(CTRL_SEQ0);
		tx_q.push_back(addr_reg ^ 8'h80);
		// flags inside a header restart it
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(addr_reg);
		tx_q.push_back(FLAG_BYTE);
		tx_q.push_back(addr_reg);
		tx_q.push_back(CTRL_SEQ1);
		body_q = {8'h42};
		put_frame(want_seq, 1'b0);
		send_tx();
	endtask

	task automatic test_long_frames();
		fill_body(FRAME_MAX);
		put_frame(want_seq, 1'b0);
		send_tx();
		put_header(want_seq);
		repeat (FRAME_MAX + 2) put_stuffed(rnd_byte());
		send_tx();
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_req_cycles = 120;
		fill_body(40);
		put_frame(want_seq, 1'b0);
		send_tx();
	endtask

	task automatic test_addresses();
		logic [7:0] addrs[4];
		addrs = '{8'h00, 8'hFF, FLAG_BYTE, 8'($urandom_range(0, 255))};
		foreach (addrs[i]) begin
			load_link_address(addrs[i]);
			tx_q.push_back(FLAG_BYTE);
			tx_q.push_back(addrs[i] ^ 8'h01);
			fill_body($urandom_range(0, 4));
			put_frame(want_seq, 1'b0);
			fill_body(2);
			put_frame(~want_seq, 1'b0);
			send_tx();
		end
	endtask

	task automatic test_random_traffic();
		int start;
		int noise;
		int len;
		int pick;
		int k;
		logic s;
		logic [7:0] b;
		load_link_address(8'($urandom_range(0, 255)));
		start = n_sent;
		noise = 0;
		while (n_sent - start - noise < RANDOM_ITEMS) begin
			if (n_sent - start - noise < RANDOM_ITEMS * 3 / 4)
				idling = ($urandom_range(0, 3) != 0);
			else
				idling = 1'b0;
			s = ($urandom_range(0, 9) < 7) ? want_seq : ~want_seq;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				fill_body(len);
				put_frame(s, 1'b0);
			end else if (pick < 70) begin
				fill_body(len);
				put_frame(s, 1'b1);
			end else if (pick < 77) begin
				put_header(s);
				repeat (len) put_stuffed(rnd_byte());
				do b = 8'($urandom_range(0, 255)); while (b == ESC_FLAG || b == ESC_ESC);
				tx_q.push_back(ESC_BYTE);
				tx_q.push_back(b);
			end else if (pick < 82) begin
				put_header(s);
				tx_q.push_back(FLAG_BYTE);
			end else if (pick < 90) begin
				put_header(s);
				k = $urandom_range(1, 3);
				tx_q[k] = tx_q[k] ^ 8'($urandom_range(1, 255));
				repeat (len) put_stuffed(rnd_byte());
			end else begin
				// line noise while hunting
				k = $urandom_range(1, 5);
				repeat (k) tx_q.push_back(8'($urandom_range(0, 255)));
				noise += k;
			end
			send_tx();
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_good_frames();
		test_error_frames();
		test_long_frames();
		test_backpressure();
		test_addresses();
		test_random_traffic();
		wait_idle();
		repeat (8) @(negedge clk);
		if (n_err == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/swfr_pkg.sv
rtl/swfr_front.sv
rtl/swfr_cmd_fifo.sv
rtl/swfr_back.sv
rtl/stop_and_wait_frame_receiver.sv
test/tb_top.sv
